// ===== rtl/core/f64sif_pkg.sv =====
// shared constants and stage types for the float64 int/frac split pipeline
`timescale 1ns / 1ps
package f64sif_pkg;
    localparam int MANT_W = 52;
    localparam int EXP_W = 11;
    localparam logic [EXP_W-1:0] EXP_BIAS = 11'h3FF;
    localparam logic [EXP_W-1:0] EXP_ALL1 = 11'h7FF;
    localparam logic [EXP_W-1:0] EXP_INT_LIM = 11'h433;  // 1023 + 52

    // decoded item after the first stage
    typedef struct packed {
        logic             vld;
        logic [63:0]      v;
        logic [11:0]      ue;
        logic             pass_int;   // value is its own integer part
        logic             pass_frac;  // value is its own fraction
        logic [51:0]      fm;         // fraction mantissa bits
        logic [63:0]      ipart;
    } dec_t;

    // after leading-one search
    typedef struct packed {
        logic             vld;
        logic [63:0]      v;
        logic [11:0]      ue;
        logic             pass_int;
        logic             pass_frac;
        logic             fzero;
        logic [51:0]      fm;
        logic [5:0]       lz;         // leading zeros of fm within 52 bits
        logic [63:0]      ipart;
    } lzc_t;
endpackage

// ===== rtl/core/float64_split_int_frac_top.sv =====
// top level of the float64 integer/fraction split pipeline
// Splits a binary64 value into unbiased exponent, integer part, fraction part and
// signed significand. Fully pipelined: one operand may be started every cycle
// (busy is always low) and its result appears with the done strobe after the
// decode, leading-zero and pack register stages. Results are shown for one cycle
// only; the receiver must take every transfer.
`timescale 1ns / 1ps
module float64_split_int_frac_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] value_bits,
    output logic        done,
    output logic [11:0] unbiased_exponent,
    output logic [63:0] integer_part_bits,
    output logic [63:0] fraction_part_bits,
    output logic [63:0] significand_bits
);
    import f64sif_pkg::*;

    dec_t dec;
    lzc_t lzc;

    assign busy = 1'b0;

    f64sif_decode u_decode
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_vld     (start),
        .value_bits (value_bits),
        .dec        (dec)
    );

    f64sif_lzc u_lzc
    (
        .clk   (clk),
        .rst_n (rst_n),
        .dec   (dec),
        .lzc   (lzc)
    );

    f64sif_pack u_pack
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .lzc                (lzc),
        .done               (done),
        .unbiased_exponent  (unbiased_exponent),
        .integer_part_bits  (integer_part_bits),
        .fraction_part_bits (fraction_part_bits),
        .significand_bits   (significand_bits)
    );

    // every start transfer gives a matching done
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##3 done) else $error("missing result");
    a_nospur: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(lzc.vld)) else $error("spurious result");
    a_sig: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> significand_bits[62:52] == EXP_BIAS) else $error("bad significand");
endmodule

// ===== rtl/core/f64sif_decode.sv =====
// stage 1: field decode and integer part mask
`timescale 1ns / 1ps
module f64sif_decode
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_vld,
    input  logic [63:0]          value_bits,
    output f64sif_pkg::dec_t     dec
);
    import f64sif_pkg::*;

    dec_t dec_reg;
    dec_t dec_next;
    logic [10:0] ef;
    logic [5:0]  nf;
    logic [51:0] fmask;

    always_comb
    begin
        ef = value_bits[62:52];
        nf = 6'(EXP_INT_LIM - ef);
        fmask = ~(52'hF_FFFF_FFFF_FFFF << nf);
        dec_next.vld = in_vld;
        dec_next.v = value_bits;
        dec_next.ue = {1'b0, ef} - {1'b0, EXP_BIAS};
        dec_next.pass_int = (ef == EXP_ALL1) || (ef >= EXP_INT_LIM);
        dec_next.pass_frac = ef < EXP_BIAS;
        dec_next.fm = value_bits[51:0] & fmask;
        dec_next.ipart = {value_bits[63:52], value_bits[51:0] & ~fmask};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_reg <= '0;
        end
        else
        begin
            dec_reg <= dec_next;
        end
    end

    assign dec = dec_reg;
endmodule

// ===== rtl/core/f64sif_lzc.sv =====
// stage 2: leading-zero count of the fraction bits
`timescale 1ns / 1ps
module f64sif_lzc
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  f64sif_pkg::dec_t     dec,
    output f64sif_pkg::lzc_t     lzc
);
    import f64sif_pkg::*;

    lzc_t lzc_reg;
    lzc_t lzc_next;
    logic [5:0] cnt;
    logic       found;

    always_comb
    begin
        cnt = '0;
        found = 1'b0;
        for (int i = MANT_W - 1; i >= 0; i--)
        begin
            if (!found && dec.fm[i])
            begin
                found = 1'b1;
                cnt = 6'(MANT_W - 1 - i);
            end
        end
        lzc_next.vld = dec.vld;
        lzc_next.v = dec.v;
        lzc_next.ue = dec.ue;
        lzc_next.pass_int = dec.pass_int;
        lzc_next.pass_frac = dec.pass_frac;
        lzc_next.fzero = !found;
        lzc_next.fm = dec.fm;
        lzc_next.lz = cnt;
        lzc_next.ipart = dec.ipart;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lzc_reg <= '0;
        end
        else
        begin
            lzc_reg <= lzc_next;
        end
    end

    assign lzc = lzc_reg;
endmodule

// ===== rtl/core/f64sif_pack.sv =====
// stage 3: normalize fraction and build the four results
`timescale 1ns / 1ps
module f64sif_pack
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  f64sif_pkg::lzc_t     lzc,
    output logic                 done,
    output logic [11:0]          unbiased_exponent,
    output logic [63:0]          integer_part_bits,
    output logic [63:0]          fraction_part_bits,
    output logic [63:0]          significand_bits
);
    import f64sif_pkg::*;

    logic        done_reg;
    logic [11:0] ue_reg;
    logic [63:0] ip_reg, ip_next;
    logic [63:0] fp_reg, fp_next;
    logic [63:0] sg_reg;
    logic [51:0] norm;
    logic [10:0] nexp;
    logic [63:0] sign;

    always_comb
    begin
        sign = {lzc.v[63], 63'd0};
        // leading one at bit p = 51 - lz, shift by 52 - p drops it
        norm = lzc.fm << (lzc.lz + 6'd1);
        nexp = 11'(lzc.ue) + EXP_BIAS - 11'(lzc.lz) - 11'd1;
        if (lzc.pass_int)
        begin
            ip_next = lzc.v;
            fp_next = sign;
        end
        else if (lzc.pass_frac)
        begin
            ip_next = sign;
            fp_next = lzc.v;
        end
        else
        begin
            ip_next = lzc.ipart;
            fp_next = lzc.fzero ? sign : {lzc.v[63], nexp, norm};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= lzc.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        ue_reg <= lzc.ue;
        ip_reg <= ip_next;
        fp_reg <= fp_next;
        sg_reg <= {lzc.v[63], EXP_BIAS, lzc.v[51:0]};
    end

    assign done = done_reg;
    assign unbiased_exponent = ue_reg;
    assign integer_part_bits = ip_reg;
    assign fraction_part_bits = fp_reg;
    assign significand_bits = sg_reg;
endmodule

// ===== bench/tb_float64_split_int_frac_top.sv =====
// testbench for the float64 integer/fraction split block
`timescale 1ns / 1ps
module tb_float64_split_int_frac_top;
    import f64sif_pkg::*;

    typedef struct packed {
        logic [11:0] ue;
        logic [63:0] ipart;
        logic [63:0] fpart;
        logic [63:0] sig;
    } split_t;

    localparam int N_RANDOM = 1100;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [63:0] SIGN_MASK = 64'h8000_0000_0000_0000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [63:0] value_bits;
    logic        done;
    logic [11:0] unbiased_exponent;
    logic [63:0] integer_part_bits;
    logic [63:0] fraction_part_bits;
    logic [63:0] significand_bits;

    logic [63:0] pending_values[$];
    int          pending_gaps[$];
    logic [63:0] hold_values[$];   // items held back until results drain
    split_t      expected_splits[$];
    int          mismatches;
    int          results_seen;
    int          items_sent;
    int          gap_left;
    int          cycles;
    bit          stimulus_done;
    bit          hold_active;

    float64_split_int_frac_top dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .value_bits(value_bits),
        .done(done),
        .unbiased_exponent(unbiased_exponent),
        .integer_part_bits(integer_part_bits),
        .fraction_part_bits(fraction_part_bits),
        .significand_bits(significand_bits)
    );

    function automatic split_t predict_split(logic [63:0] v);
        split_t      r;
        logic [63:0] sgn;
        logic [10:0] ef;
        logic [51:0] mant;
        logic [51:0] fmask;
        logic [51:0] fm;
        int          e;
        int          p;
        logic [10:0] nexp;
        sgn = v & SIGN_MASK;
        ef = v[62:52];
        mant = v[51:0];
        e = int'(ef) - int'(EXP_BIAS);
        r.ue = e[11:0];
        r.sig = sgn | {1'b0, EXP_BIAS, mant};
        if (ef == EXP_ALL1 || e >= MANT_W) begin
            r.ipart = v;
            r.fpart = sgn;
        end
        else if (e < 0) begin
            r.ipart = sgn;
            r.fpart = v;
        end
        else begin
            fmask = (52'd1 << (MANT_W - e)) - 52'd1;
            fm = mant & fmask;
            r.ipart = v & ~{12'd0, fmask};
            if (fm == 0) begin
                r.fpart = sgn;
            end
            else begin
                p = MANT_W - 1;
                while (p > 0 && !fm[p])
                    p--;
                nexp = 11'(int'(EXP_BIAS) + p + e - MANT_W);
                r.fpart = sgn | {1'b0, nexp, 52'(fm << (MANT_W - p))};
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] random_value();
        logic [63:0] v;
        int          pick;
        v = {$urandom, $urandom};
        pick = $urandom_range(0, 9);
        // bias the exponent toward the interesting window around 0..52
        if (pick < 6)
            v[62:52] = 11'($urandom_range(1023 - 3, 1023 + 54));
        else if (pick == 6)
            v[62:52] = $urandom_range(0, 1) ? 11'd0 : EXP_ALL1;
        else if (pick == 7)
            v[51:0] = v[51:0] & ~((52'd1 << $urandom_range(0, 52)) - 52'd1);
        return v;
    endfunction

    function automatic void queue_item(logic [63:0] v);
        pending_values.push_back(v);
        pending_gaps.push_back($urandom_range(0, 3) == 0 ? $urandom_range(0, 10) : 0);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        logic [63:0] directed[$];
        directed = '{64'h0, SIGN_MASK, 64'h0000_0000_0000_0001, 64'h800F_FFFF_FFFF_FFFF,
                     64'h3FF0_0000_0000_0000, 64'hBFF8_0000_0000_0000,
                     64'h3FEF_FFFF_FFFF_FFFF, 64'h4008_0000_0000_0001,
                     64'h4330_0000_0000_0000, 64'h432F_FFFF_FFFF_FFFF,
                     64'hC32F_FFFF_FFFF_FFFE, 64'h7FF0_0000_0000_0000,
                     64'hFFF0_0000_0000_0000, 64'h7FF8_0000_0000_0001,
                     64'h7FEF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                     64'h4000_0000_0000_0000, 64'hC059_0000_0000_0000,
                     64'h400921FB54442D18, 64'h5555_5555_5555_5555,
                     64'hAAAA_AAAA_AAAA_AAAA};
        foreach (directed[i])
            queue_item(directed[i]);
        for (int i = 0; i < N_RANDOM; i++)
            if (i < 150)
                queue_item(random_value());
            else
                hold_values.push_back(random_value());
        stimulus_done = 1'b0;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            start <= 1'b0;
            value_bits <= '0;
            gap_left <= 0;
            items_sent <= 0;
            hold_active <= 1'b0;
        end
        else begin
            if (start && !busy) begin
                expected_splits.push_back(predict_split(value_bits));
                items_sent <= items_sent + 1;
            end
            if (start && busy) begin
                // keep offering the same item
            end
            else if (pending_values.size() == 0 && hold_values.size() != 0) begin
                // pause until every expected result has arrived, then release the rest
                start <= 1'b0;
                if (!hold_active)
                    hold_active <= 1'b1;
                else if (expected_splits.size() == 0 && !(start && !busy)) begin
                    while (hold_values.size() != 0)
                        queue_item(hold_values.pop_front());
                end
            end
            else if (gap_left > 0) begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_values.size() != 0) begin
                start <= 1'b1;
                value_bits <= pending_values.pop_front();
                gap_left <= pending_gaps.pop_front();
            end
            else begin
                start <= 1'b0;
                value_bits <= {$urandom, $urandom};
                stimulus_done <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        split_t want;
        split_t got;
        if (rst_n && done) begin
            got = '{unbiased_exponent, integer_part_bits, fraction_part_bits,
                    significand_bits};
            results_seen <= results_seen + 1;
            if (expected_splits.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected transfer: %h", got);
            end
            else begin
                want = expected_splits.pop_front();
                if (got !== want) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: exp ue=%h int=%h frac=%h sig=%h got ue=%h int=%h frac=%h sig=%h",
                                 want.ue, want.ipart, want.fpart, want.sig,
                                 got.ue, got.ipart, got.fpart, got.sig);
                end
            end
        end
    end

    initial
    begin
        mismatches = 0;
        results_seen = 0;
        cycles = 0;
        rst_n = 1'b0;
        start = 1'b0;
        value_bits = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        while (!(stimulus_done && expected_splits.size() == 0) && cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
        repeat (10) @(posedge clk);
        $display("sent %0d values, checked %0d results across zero, subnormal, fraction,",
                 items_sent, results_seen);
        $display("large integer, infinity and nan ranges; %0d mismatches", mismatches);
        if (mismatches == 0 && expected_splits.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// ===== float64_split_int_frac_top.f =====
rtl/core/f64sif_pkg.sv
rtl/core/f64sif_decode.sv
rtl/core/f64sif_lzc.sv
rtl/core/f64sif_pack.sv
rtl/core/float64_split_int_frac_top.sv
bench/tb_float64_split_int_frac_top.sv
